// ----- rtl/rhht_pkg.sv -----
package rhht_pkg;

  localparam int unsigned SlotBits  = 10;
  localparam int unsigned Slots     = 1 << SlotBits;
  localparam int unsigned CapW      = 11;
  localparam int unsigned HashW     = 32;
  localparam int unsigned KeyW      = 128;
  localparam int unsigned ValW      = 256;
  localparam int unsigned KindW     = 8;
  localparam int unsigned StatW     = 2;
  localparam int unsigned InDataW   = 432;
  localparam int unsigned OutDataW  = 272;
  localparam int unsigned EntryW    = 1 + HashW + KeyW + ValW + KindW;

  localparam logic [StatW-1:0] StatOk      = 2'd0;
  localparam logic [StatW-1:0] StatMiss    = 2'd1;
  localparam logic [StatW-1:0] StatFull    = 2'd2;
  localparam logic              ModeInsert = 1'b0;

  typedef logic [SlotBits-1:0] slot_t;

  typedef struct packed {
    logic             used;
    logic [KindW-1:0] kind;
    logic [ValW-1:0]  val;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
  } entry_t;

  typedef struct packed {
    logic  rd;
    logic  wr;
    slot_t addr;
    entry_t wdata;
  } mem_req_t;

  function automatic slot_t home_of(input logic [HashW-1:0] h);
    return h[SlotBits-1:0];
  endfunction

endpackage

// ----- rtl/rhht_store.sv -----
module rhht_store (
  input  logic               clk_i,
  input  rhht_pkg::mem_req_t req_i,
  output rhht_pkg::entry_t   rdata_o
);
  import rhht_pkg::*;

  entry_t mem_q [Slots];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_o <= mem_q[req_i.addr];
    end
  end

endmodule

// ----- rtl/robin_hood_hash_table_core.sv -----
// channel   dir  handshake             payload
// s_axis    in   s_axis_tvalid/tready  tdata: mode key_low key_high key_hash value_word0..3 kind
// m_axis    out  m_axis_tvalid/tready  tdata: status found_word0..3 found_kind
// cfg       in   cfg_valid/cfg_ready   cfg_data: key cap
// after reset a clearing pass writes every slot, one a cycle, no item taken
// each item walks its probe sequence, reading and then deciding at each probed slot
// one shared memory port and one compare / distance unit serve every probe
// result sits in an output register; the next item is taken once it is delivered
module robin_hood_hash_table_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [rhht_pkg::InDataW-1:0] s_axis_tdata,  // mode, key_low, key_high, key_hash,
                                                       // value_word0..3, value_kind, pad
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [rhht_pkg::OutDataW-1:0] m_axis_tdata, // status, found_word0..3, found_kind, pad
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rhht_pkg::CapW-1:0] cfg_data
);
  import rhht_pkg::*;

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StRead  = 6'b000100,
    StEval  = 6'b001000,
    StOut   = 6'b010000,
    StWait  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  slot_t pos_q, pos_d;
  logic [SlotBits:0] dist_q, dist_d;
  logic [SlotBits:0] keys_q, keys_d;
  logic [CapW-1:0] max_q;
  logic mode_q, mode_d, moved_q, moved_d;
  entry_t carry_q, carry_d;
  logic [StatW-1:0] stat_q, stat_d;
  entry_t res_q, res_d;
  mem_req_t req;
  entry_t rdata;
  logic s_used, match, closer, cap;
  slot_t occ;

  rhht_store u_store (.clk_i, .req_i(req), .rdata_o(rdata));

  assign s_used = rdata.used;
  assign match  = rdata.hash == carry_q.hash && rdata.key == carry_q.key;
  assign occ    = pos_q - home_of(rdata.hash);
  assign closer = {1'b0, occ} < dist_q;
  assign cap    = ({1'b0, keys_q} >= {1'b0, max_q}) || (keys_q >= (SlotBits+1)'(Slots));

  assign s_axis_tready = state_q == StIdle;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = state_q == StOut;
  assign m_axis_tdata  = {{(OutDataW-StatW-ValW-KindW){1'b0}}, res_q.kind, res_q.val, stat_q};

  always_comb begin
    state_d = state_q; pos_d = pos_q; dist_d = dist_q;
    keys_d = keys_q; mode_d = mode_q; moved_d = moved_q; carry_d = carry_q;
    stat_d = stat_q; res_d = res_q;
    req = '{rd: 1'b0, wr: 1'b0, addr: pos_q, wdata: carry_q};
    case (state_q)
      StClear: begin
        req.wr = 1'b1; req.wdata = '0;
        pos_d = pos_q + 1'b1;
        if (pos_q == slot_t'(Slots-1)) state_d = StIdle;
      end
      StIdle: begin
        if (s_axis_tvalid) begin
          mode_d = s_axis_tdata[0];
          carry_d.used = 1'b1;
          carry_d.key  = s_axis_tdata[128:1];
          carry_d.hash = s_axis_tdata[160:129];
          carry_d.val  = s_axis_tdata[416:161];
          carry_d.kind = s_axis_tdata[424:417];
          pos_d = home_of(s_axis_tdata[160:129]);
          dist_d = '0; moved_d = 1'b0;
          state_d = StRead;
        end
      end
      StRead: begin
        req.rd = 1'b1;
        state_d = StEval;
      end
      StEval: begin
        res_d = '0;
        state_d = StOut;
        if (mode_q != ModeInsert) begin
          if (!s_used) stat_d = StatMiss;
          else if (match) begin stat_d = StatOk; res_d = rdata; end
          else if (closer) stat_d = StatMiss;
          else if (dist_q >= (SlotBits+1)'(Slots-1)) stat_d = StatMiss;
          else begin pos_d = pos_q + 1'b1; dist_d = dist_q + 1'b1; state_d = StRead; end
        end else begin
          if (!s_used) begin
            if (!moved_q && cap) stat_d = StatFull;
            else begin
              req.wr = 1'b1;
              keys_d = keys_q + 1'b1; stat_d = StatOk;
            end
          end else if (match) begin
            req.wr = 1'b1; stat_d = StatOk;
          end else if (closer && !moved_q && cap) begin
            stat_d = StatFull;
          end else begin
            if (closer) begin
              req.wr = 1'b1; moved_d = 1'b1; carry_d = rdata;
              dist_d = {1'b0, occ} + 1'b1;
            end else dist_d = dist_q + 1'b1;
            pos_d = pos_q + 1'b1;
            if (dist_d >= (SlotBits+1)'(Slots)) stat_d = StatFull;
            else state_d = StRead;
          end
        end
      end
      StOut: begin
        if (m_axis_tready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      pos_q   <= '0;
      keys_q  <= '0;
      max_q   <= CapW'(Slots);
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      keys_q  <= keys_d;
      if (cfg_valid) max_q <= cfg_data;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d; mode_q <= mode_d; moved_q <= moved_d;
    carry_q <= carry_d; stat_q <= stat_d; res_q <= res_d;
  end

endmodule
